/* rtl/stft_pkg.sv */
// Shared constants, payload types and constant tables for the STFT analysis block.
// The window and twiddle tables are built at elaboration by a CORDIC routine; the arc table is a literal.
// Depends on nothing; every other file imports it.
package stft_pkg;

   localparam int FRAME_LEN    = 64;
   localparam int FFT_LOG2     = $clog2(FRAME_LEN);
   localparam int HALF_SIZE    = FRAME_LEN / 2;
   localparam int HOP_W        = 7;
   localparam int HOP_RESET    = 16;
   localparam int SAMPLE_W     = 16;
   localparam int BIN_NUM_W    = 6;
   localparam int BIN_W        = 23;
   localparam int MAG_W        = 23;
   localparam int PHASE_W      = 16;
   localparam int CORDIC_STEPS = 22;
   localparam int SQ_ITERS     = 23;
   localparam int MAG_MAX      = 8388607;
   localparam int QUARTER_TURN = 4194304;

   localparam longint ONE_Q30      = 64'sd1073741824;
   localparam longint GAIN_Q30     = 64'sd652032874;
   localparam longint TURN_MASK    = 64'sh0000_0000_00FF_FFFF;
   localparam longint QUARTER_MASK = 64'sh0000_0000_003F_FFFF;

   typedef logic        [HOP_W-1:0]     hop_type;
   typedef logic signed [SAMPLE_W-1:0]  sample_type;
   typedef logic        [BIN_NUM_W-1:0] bin_num_type;
   typedef logic signed [BIN_W-1:0]     bin_val_type;
   typedef logic        [MAG_W-1:0]     mag_type;
   typedef logic signed [PHASE_W-1:0]   phase_type;

   typedef int                 arc_tab_type  [CORDIC_STEPS];
   typedef logic        [14:0] hann_tab_type [FRAME_LEN];
   typedef logic signed [31:0] twid_tab_type [HALF_SIZE];

   localparam arc_tab_type ARC_STEPS = '{
      2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
      10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1
   };

   function automatic longint rotate_part(input longint r, input bit want_sin);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      int     i;
      x = GAIN_Q30;
      y = 0;
      z = r;
      if (r == 0) begin
         x = ONE_Q30;
      end else begin
         for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx;
               y = y + dy;
               z = z - longint'(ARC_STEPS[i]);
            end else begin
               x = x + dx;
               y = y - dy;
               z = z + longint'(ARC_STEPS[i]);
            end
         end
      end
      return want_sin ? y : x;
   endfunction

   function automatic longint cos_sin(input longint angle, input bit want_sin);
      longint a;
      longint rc;
      longint rs;
      longint res;
      a  = angle & TURN_MASK;
      rc = rotate_part(a & QUARTER_MASK, 1'b0);
      rs = rotate_part(a & QUARTER_MASK, 1'b1);
      case ((a >> 22) & 3)
         0:       res = want_sin ? rs  : rc;
         1:       res = want_sin ? rc  : -rs;
         2:       res = want_sin ? -rs : -rc;
         default: res = want_sin ? -rc : rs;
      endcase
      return res;
   endfunction

   function automatic longint angle_of(input int n);
      return ((longint'(n) << 24) / FRAME_LEN) & TURN_MASK;
   endfunction

   function automatic hann_tab_type build_hann();
      hann_tab_type t;
      longint       w;
      int           n;
      for (n = 0; n < FRAME_LEN; n++) begin
         w = ONE_Q30 - cos_sin(angle_of(n), 1'b0) + 32768;
         w = (w < 0) ? 0 : (w >>> 16);
         if (w > 32767) begin
            w = 32767;
         end
         t[n] = w[14:0];
      end
      return t;
   endfunction

   function automatic twid_tab_type build_twid(input bit want_im);
      twid_tab_type t;
      longint       v;
      int           n;
      for (n = 0; n < HALF_SIZE; n++) begin
         v    = want_im ? -cos_sin(angle_of(n), 1'b1) : cos_sin(angle_of(n), 1'b0);
         t[n] = v[31:0];
      end
      return t;
   endfunction

   localparam hann_tab_type HANN   = build_hann();
   localparam twid_tab_type TWID_RE = build_twid(1'b0);
   localparam twid_tab_type TWID_IM = build_twid(1'b1);

   function automatic logic [FFT_LOG2-1:0] bit_rev(input logic [FFT_LOG2-1:0] v);
      logic [FFT_LOG2-1:0] r;
      for (int b = 0; b < FFT_LOG2; b++) begin
         r[b] = v[FFT_LOG2-1-b];
      end
      return r;
   endfunction

endpackage

/* rtl/stft_req_if.sv */
// Sample channel into the STFT analysis block: valid, ready and one audio sample.
// Depends on stft_pkg for the sample type.
interface stft_req_if;
   import stft_pkg::*;

   logic       valid;
   logic       ready;
   sample_type sample_value;

   modport source (output valid, output sample_value, input ready);
   modport sink   (input valid, input sample_value, output ready);
endinterface

/* rtl/stft_rsp_if.sv */
// Bin channel out of the STFT analysis block: valid, ready and one frequency bin.
// Depends on stft_pkg for the field types.
interface stft_rsp_if;
   import stft_pkg::*;

   logic        valid;
   logic        ready;
   bin_num_type bin_number;
   bin_val_type bin_real;
   bin_val_type bin_imag;
   mag_type     bin_magnitude;
   phase_type   bin_phase;
   logic        frame_last;

   modport source (output valid, output bin_number, output bin_real, output bin_imag,
                   output bin_magnitude, output bin_phase, output frame_last,
                   input ready);
   modport sink   (input valid, input bin_number, input bin_real, input bin_imag,
                   input bin_magnitude, input bin_phase, input frame_last,
                   output ready);
endinterface

/* rtl/stft_analysis_frame.sv */
// Short-time Fourier analysis: sample history, Hann window, radix-2 FFT, bin output.
// Depends on stft_pkg, stft_req_if and stft_rsp_if.
//
//   channel   direction  carries                                    handshake
//   req_chan  in         one audio sample per item                  valid/ready
//   rsp_chan  out        one bin per item, FRAME_LEN/2+1 per frame  valid/ready
//   csr       in         hop_length                                 write enable
//
// A sample that does not close a hop is taken and the block stays idle. A sample
// that closes a hop starts a frame whose length is set by the single shared
// multiplier and the one-step-per-cycle square root and phase CORDIC; the block
// is not ready during the frame.
// Reset clears the control state and empties the history through its fill count.
// A stalled bin waits in the output register and holds the sequencer in place.
module stft_analysis_frame (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  stft_pkg::hop_type csr_wr_data,
   stft_req_if.sink          req_chan,
   stft_rsp_if.source        rsp_chan
);
   import stft_pkg::*;

   localparam int CNT_W  = FFT_LOG2 + 1;
   localparam int STG_W  = $clog2(FFT_LOG2);
   localparam int ITER_W = $clog2(SQ_ITERS);
   localparam int ST_W   = 2 * BIN_W;
   localparam int SQ_W   = 47;
   localparam int CX_W   = 35;
   localparam int CZ_W   = 25;

   // The sequencer walks load, butterflies and bin output in that order.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LD_RD,
      ST_LD_MUL,
      ST_LD_WR,
      ST_BF,
      ST_OUT_RD,
      ST_OUT_CAP,
      ST_OUT_SQ,
      ST_OUT_SUM,
      ST_OUT_ITER,
      ST_OUT_EMIT
   } state_type;

   state_type state_ff, state_in;

   logic [FFT_LOG2-1:0] idx_ff, idx_in;
   logic [STG_W-1:0]    stage_ff, stage_in;
   logic [2:0]          step_ff, step_in;
   logic [ITER_W-1:0]   it_ff, it_in;
   logic [FFT_LOG2-1:0] wp_ff, wp_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   hop_type             hop_cnt_ff, hop_cnt_in;
   hop_type             hop_len_ff, hop_len_in;
   logic                rv_ff, rv_in;

   logic                hok_ff, hok_in;
   logic signed [55:0]  prod_ff, prod_in;
   logic signed [56:0]  acc_ff, acc_in;
   logic signed [23:0]  tr_ff, tr_in;
   logic signed [23:0]  ti_ff, ti_in;
   bin_val_type         re_ff, re_in;
   bin_val_type         im_ff, im_in;
   logic                rim_ff, rim_in;
   logic                zero_ff, zero_in;
   logic [SQ_W-1:0]     rem_ff, rem_in;
   logic [SQ_W-1:0]     root_ff, root_in;
   logic [SQ_W-1:0]     sbit_ff, sbit_in;
   logic signed [CX_W-1:0] cx_ff, cx_in;
   logic signed [CX_W-1:0] cy_ff, cy_in;
   logic signed [CZ_W-1:0] cz_ff, cz_in;
   bin_num_type         rnum_ff, rnum_in;
   bin_val_type         rre_ff, rre_in;
   bin_val_type         rimv_ff, rimv_in;
   mag_type             rmag_ff, rmag_in;
   phase_type           rph_ff, rph_in;
   logic                rlast_ff, rlast_in;

   // Memories and their registered read data.
   sample_type          hist_mem [FRAME_LEN];
   sample_type          hist_rd_ff;
   logic [ST_W-1:0]     st_mem [FRAME_LEN];
   logic [ST_W-1:0]     st_rd_a_ff;
   logic [ST_W-1:0]     st_rd_b_ff;

   logic                hist_we;
   logic [FFT_LOG2-1:0] hist_ra;
   logic                st_we;
   logic [FFT_LOG2-1:0] st_wa;
   logic [ST_W-1:0]     st_wd;
   logic [FFT_LOG2-1:0] st_ra_a;
   logic [FFT_LOG2-1:0] st_ra_b;

   // Shared multiplier operands.
   logic signed [23:0]  mul_a;
   logic signed [31:0]  mul_b;

   // Butterfly addressing.
   logic [FFT_LOG2-1:0] b_ext, bmask, hbit, top_addr, bot_addr, tw_raw;
   logic [STG_W-1:0]    tw_shift;
   logic [FFT_LOG2-2:0] tw_k;
   logic signed [31:0]  wr, wi;
   bin_val_type         ar, ai, br, bi;

   logic signed [56:0]  rnd_full;
   logic signed [23:0]  rnd_c;
   logic signed [55:0]  win_full;
   logic signed [23:0]  top_re, top_im, bot_re, bot_im;

   hop_type             hop_eff;
   hop_type             hop_next;
   logic                req_take;
   logic                can_load;
   logic [SQ_W-1:0]     ssum;
   logic [SQ_W-1:0]     mag_full;
   logic [45:0]         pow_sum;
   logic signed [CX_W-1:0] x0, y0, dx, dy;
   logic signed [CZ_W-1:0] arc_c, pacc;
   bin_val_type         cap_re, cap_im;

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign req_take             = req_chan.valid && (state_ff == ST_IDLE);
   assign can_load             = !rv_ff || rsp_chan.ready;

   assign rsp_chan.valid         = rv_ff;
   assign rsp_chan.bin_number    = rnum_ff;
   assign rsp_chan.bin_real      = rre_ff;
   assign rsp_chan.bin_imag      = rimv_ff;
   assign rsp_chan.bin_magnitude = rmag_ff;
   assign rsp_chan.bin_phase     = rph_ff;
   assign rsp_chan.frame_last    = rlast_ff;

   // A zero hop acts as one; a hop beyond the frame saturates at the frame.
   always_comb begin
      if (hop_len_ff == '0) begin
         hop_eff = HOP_W'(1);
      end else if (hop_len_ff > HOP_W'(FRAME_LEN)) begin
         hop_eff = HOP_W'(FRAME_LEN);
      end else begin
         hop_eff = hop_len_ff;
      end
   end
   assign hop_next = hop_cnt_ff + HOP_W'(1);

   // Butterfly of stage s pairs top and top + 2^s; its twiddle index is j * N/2^(s+1).
   assign b_ext    = {1'b0, idx_ff[FFT_LOG2-2:0]};
   assign bmask    = ~({FFT_LOG2{1'b1}} << stage_ff);
   assign hbit     = FFT_LOG2'(1) << stage_ff;
   assign top_addr = ((b_ext & ~bmask) << 1) | (b_ext & bmask);
   assign bot_addr = top_addr | hbit;
   assign tw_shift = STG_W'(FFT_LOG2 - 1) - stage_ff;
   assign tw_raw   = (b_ext & bmask) << tw_shift;
   assign tw_k     = tw_raw[FFT_LOG2-2:0];
   assign wr       = TWID_RE[tw_k];
   assign wi       = TWID_IM[tw_k];

   assign ar = st_rd_a_ff[ST_W-1:BIN_W];
   assign ai = st_rd_a_ff[BIN_W-1:0];
   assign br = st_rd_b_ff[ST_W-1:BIN_W];
   assign bi = st_rd_b_ff[BIN_W-1:0];

   // Twiddle products are rounded half up at 2^30, windowed samples at 2^15.
   // The top imaginary part is written in the cycle its product is rounded.
   assign rnd_full = (acc_ff + 57'sd536870912) >>> 30;
   assign rnd_c    = rnd_full[23:0];
   assign win_full = (prod_ff + 56'sd16384) >>> 15;
   assign top_re   = 24'(ar) + tr_ff;
   assign bot_re   = 24'(ar) - tr_ff;
   assign top_im   = 24'(ai) + rnd_c;
   assign bot_im   = 24'(ai) - ti_ff;

   assign hist_ra = wp_ff + idx_ff;
   assign hist_we = req_take;
   assign st_ra_a = (state_ff == ST_BF) ? top_addr : idx_ff;
   assign st_ra_b = bot_addr;

   assign prod_in = mul_a * mul_b;

   // Square root and phase CORDIC share the iteration counter.
   assign ssum     = root_ff + sbit_ff;
   assign mag_full = root_ff + SQ_W'(rem_ff > root_ff);
   assign pow_sum  = acc_ff[45:0] + prod_ff[45:0];
   assign x0       = CX_W'(re_ff) <<< 8;
   assign y0       = CX_W'(im_ff) <<< 8;
   assign dx       = cy_ff >>> it_ff;
   assign dy       = cx_ff >>> it_ff;
   assign arc_c    = CZ_W'(ARC_STEPS[it_ff]);
   assign pacc     = cz_ff + CZ_W'(128);

   assign cap_re = ar;
   assign cap_im = ((idx_ff == '0) || (idx_ff == FFT_LOG2'(HALF_SIZE))) ? '0 : ai;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      stage_in   = stage_ff;
      step_in    = step_ff;
      it_in      = it_ff;
      wp_in      = wp_ff;
      fill_in    = fill_ff;
      hop_cnt_in = hop_cnt_ff;
      hop_len_in = hop_len_ff;
      rv_in      = rv_ff;
      hok_in     = ((CNT_W'(idx_ff) + fill_ff) >= CNT_W'(FRAME_LEN));
      acc_in     = acc_ff;
      tr_in      = tr_ff;
      ti_in      = ti_ff;
      re_in      = re_ff;
      im_in      = im_ff;
      rim_in     = rim_ff;
      zero_in    = zero_ff;
      rem_in     = rem_ff;
      root_in    = root_ff;
      sbit_in    = sbit_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      rnum_in    = rnum_ff;
      rre_in     = rre_ff;
      rimv_in    = rimv_ff;
      rmag_in    = rmag_ff;
      rph_in     = rph_ff;
      rlast_in   = rlast_ff;
      mul_a      = '0;
      mul_b      = '0;
      st_we      = 1'b0;
      st_wa      = top_addr;
      st_wd      = {top_re[BIN_W-1:0], top_im[BIN_W-1:0]};

      if (csr_wr_en) begin
         hop_len_in = csr_wr_data;
      end
      if (rv_ff && rsp_chan.ready) begin
         rv_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               wp_in = wp_ff + FFT_LOG2'(1);
               if (fill_ff != CNT_W'(FRAME_LEN)) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               if (hop_next >= hop_eff) begin
                  hop_cnt_in = '0;
                  idx_in     = '0;
                  state_in   = ST_LD_RD;
               end else begin
                  hop_cnt_in = hop_next;
               end
            end
         end
         ST_LD_RD: begin
            state_in = ST_LD_MUL;
         end
         ST_LD_MUL: begin
            // History entries older than the fill count read as zero.
            mul_a    = hok_ff ? 24'(hist_rd_ff) : '0;
            mul_b    = 32'(HANN[idx_ff]);
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            st_we = 1'b1;
            st_wa = bit_rev(idx_ff);
            st_wd = {win_full[BIN_W-1:0], {BIN_W{1'b0}}};
            if (idx_ff == FFT_LOG2'(FRAME_LEN - 1)) begin
               idx_in   = '0;
               stage_in = '0;
               step_in  = '0;
               state_in = ST_BF;
            end else begin
               idx_in   = idx_ff + FFT_LOG2'(1);
               state_in = ST_LD_RD;
            end
         end
         ST_BF: begin
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd1: begin
                  mul_a = 24'(br);
                  mul_b = wr;
               end
               3'd2: begin
                  mul_a  = 24'(bi);
                  mul_b  = wi;
                  acc_in = 57'(prod_ff);
               end
               3'd3: begin
                  mul_a  = 24'(br);
                  mul_b  = wi;
                  acc_in = acc_ff - 57'(prod_ff);
               end
               3'd4: begin
                  mul_a  = 24'(bi);
                  mul_b  = wr;
                  tr_in  = rnd_c;
                  acc_in = 57'(prod_ff);
               end
               3'd5: begin
                  acc_in = acc_ff + 57'(prod_ff);
               end
               3'd6: begin
                  ti_in = rnd_c;
                  st_we = 1'b1;
                  st_wa = top_addr;
                  st_wd = {top_re[BIN_W-1:0], top_im[BIN_W-1:0]};
               end
               3'd7: begin
                  st_we = 1'b1;
                  st_wa = bot_addr;
                  st_wd = {bot_re[BIN_W-1:0], bot_im[BIN_W-1:0]};
                  if (idx_ff == FFT_LOG2'(HALF_SIZE - 1)) begin
                     idx_in = '0;
                     if (stage_ff == STG_W'(FFT_LOG2 - 1)) begin
                        state_in = ST_OUT_RD;
                     end else begin
                        stage_in = stage_ff + STG_W'(1);
                     end
                  end else begin
                     idx_in = idx_ff + FFT_LOG2'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_OUT_RD: begin
            state_in = ST_OUT_CAP;
         end
         ST_OUT_CAP: begin
            // DC and Nyquist carry no imaginary part.
            re_in    = cap_re;
            im_in    = cap_im;
            rim_in   = (idx_ff == '0) || (idx_ff == FFT_LOG2'(HALF_SIZE));
            zero_in  = (cap_re == '0) && (cap_im == '0);
            mul_a    = 24'(cap_re);
            mul_b    = 32'(cap_re);
            state_in = ST_OUT_SQ;
         end
         ST_OUT_SQ: begin
            mul_a    = 24'(im_ff);
            mul_b    = 32'(im_ff);
            acc_in   = 57'(prod_ff);
            state_in = ST_OUT_SUM;
         end
         ST_OUT_SUM: begin
            rem_in  = SQ_W'(pow_sum);
            root_in = '0;
            sbit_in = SQ_W'(1) << (2 * (SQ_ITERS - 1));
            it_in   = '0;
            // Left half-plane vectors are first turned by a quarter turn.
            if (re_ff < 0) begin
               if (im_ff >= 0) begin
                  cx_in = y0;
                  cy_in = -x0;
                  cz_in = CZ_W'(QUARTER_TURN);
               end else begin
                  cx_in = -y0;
                  cy_in = x0;
                  cz_in = -CZ_W'(QUARTER_TURN);
               end
            end else begin
               cx_in = x0;
               cy_in = y0;
               cz_in = '0;
            end
            state_in = ST_OUT_ITER;
         end
         ST_OUT_ITER: begin
            if (rem_ff >= ssum) begin
               rem_in  = rem_ff - ssum;
               root_in = (root_ff >> 1) + sbit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            if (it_ff < ITER_W'(CORDIC_STEPS)) begin
               if (cy_ff > 0) begin
                  cx_in = cx_ff + dx;
                  cy_in = cy_ff - dy;
                  cz_in = cz_ff + arc_c;
               end else begin
                  cx_in = cx_ff - dx;
                  cy_in = cy_ff + dy;
                  cz_in = cz_ff - arc_c;
               end
            end
            it_in = it_ff + ITER_W'(1);
            if (it_ff == ITER_W'(SQ_ITERS - 1)) begin
               state_in = ST_OUT_EMIT;
            end
         end
         ST_OUT_EMIT: begin
            if (can_load) begin
               rv_in   = 1'b1;
               rnum_in = bin_num_type'(idx_ff);
               rre_in  = re_ff;
               rimv_in = im_ff;
               rmag_in = (mag_full > SQ_W'(MAG_MAX)) ? mag_type'(MAG_MAX)
                                                     : mag_full[MAG_W-1:0];
               if (rim_ff) begin
                  rph_in = (re_ff < 0) ? phase_type'(-32768) : '0;
               end else if (zero_ff) begin
                  rph_in = '0;
               end else begin
                  rph_in = pacc[23:8];
               end
               rlast_in = (idx_ff == FFT_LOG2'(HALF_SIZE));
               if (idx_ff == FFT_LOG2'(HALF_SIZE)) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + FFT_LOG2'(1);
                  state_in = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         idx_ff     <= '0;
         stage_ff   <= '0;
         step_ff    <= '0;
         it_ff      <= '0;
         wp_ff      <= '0;
         fill_ff    <= '0;
         hop_cnt_ff <= '0;
         hop_len_ff <= HOP_W'(HOP_RESET);
         rv_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         stage_ff   <= stage_in;
         step_ff    <= step_in;
         it_ff      <= it_in;
         wp_ff      <= wp_in;
         fill_ff    <= fill_in;
         hop_cnt_ff <= hop_cnt_in;
         hop_len_ff <= hop_len_in;
         rv_ff      <= rv_in;
      end
      hok_ff   <= hok_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      tr_ff    <= tr_in;
      ti_ff    <= ti_in;
      re_ff    <= re_in;
      im_ff    <= im_in;
      rim_ff   <= rim_in;
      zero_ff  <= zero_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      sbit_ff  <= sbit_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      rnum_ff  <= rnum_in;
      rre_ff   <= rre_in;
      rimv_ff  <= rimv_in;
      rmag_ff  <= rmag_in;
      rph_ff   <= rph_in;
      rlast_ff <= rlast_in;
   end

   // Circular sample history; the oldest sample sits at the write pointer.
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[wp_ff] <= req_chan.sample_value;
      end
      hist_rd_ff <= hist_mem[hist_ra];
   end

   // Transform work area: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[st_wa] <= st_wd;
      end
      st_rd_a_ff <= st_mem[st_ra_a];
      st_rd_b_ff <= st_mem[st_ra_b];
   end

endmodule
